// File: hdl/radix_number_text_parser_macros.svh
// assertion helpers for the number text parser
`ifndef RADIX_NUMBER_TEXT_PARSER_MACROS_SVH
`define RADIX_NUMBER_TEXT_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, masked while dis is high
`define RNTP_CHK_NOW(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, masked while dis is high
`define RNTP_CHK_NEXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rntp_pkg.sv
package rntp_pkg;

  // field and port widths
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 6;
  localparam int MODE_W      = 2;
  localparam int DIGIT_W     = 6;
  localparam int FRAC_W      = 6;
  localparam int OUT_VALUE_W = 64;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // defaults for top level parameters
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_POINT = 2'd2;

  // register reset values and limits
  localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [MODE_W-1:0]  MODE_RST  = 2'd2;
  localparam logic [MODE_W-1:0]  MODE_W16  = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_W32  = 2'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;
  localparam logic [FRAC_W-1:0]  FRAC_MAX   = 6'd63;

  // character class decided by the front end
  typedef enum logic [2:0] {
    KIND_NUL,
    KIND_MINUS,
    KIND_PLUS,
    KIND_POINT,
    KIND_DIGIT,
    KIND_BAD
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BAD_DIGIT,
    ST_SECOND_POINT,
    ST_OVERFLOW
  } status_t;

  // one classified character in the queue
  typedef struct packed {
    kind_t               kind;
    logic [DIGIT_W-1:0]  digit;
  } item_t;

  // radix clamped to the usable range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // digit value, or DIGIT_NONE for a non-digit
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] res;
    res = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) res = DIGIT_W'(c - CH_ZERO);
    else if (c >= CH_LO_A && c <= CH_LO_Z) res = DIGIT_W'(c - CH_LO_A + LETTER_BASE);
    else if (c >= CH_UP_A && c <= CH_UP_Z) res = DIGIT_W'(c - CH_UP_A + LETTER_BASE);
    return res;
  endfunction

endpackage

// File: hdl/rntp_front.sv
module rntp_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rntp_pkg::IN_TDATA_W-1:0] in_tdata,   // [7:0] char_code
  input  logic [rntp_pkg::RADIX_W-1:0]   radix,
  input  logic                           allow_point,
  input  logic                           q_full,
  output logic                           q_push,
  output rntp_pkg::item_t                q_item
);
  import rntp_pkg::*;

  logic [CHAR_W-1:0]  c;
  logic [DIGIT_W-1:0] d;

  // accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify the character
  always_comb begin
    c = in_tdata[CHAR_W-1:0];
    d = digit_of(c);
    q_item.digit = d;
    priority if (c == CH_NUL) begin
      q_item.kind = KIND_NUL;
    end else if (c == CH_MINUS) begin
      q_item.kind = KIND_MINUS;
    end else if (c == CH_PLUS) begin
      q_item.kind = KIND_PLUS;
    end else if (c == CH_POINT) begin
      q_item.kind = allow_point ? KIND_POINT : KIND_BAD;
    end else if (d < eff_radix(radix)) begin
      q_item.kind = KIND_DIGIT;
    end else begin
      q_item.kind = KIND_BAD;
    end
  end

endmodule

// File: hdl/rntp_queue.sv
module rntp_queue #(
  parameter int DEPTH = rntp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rntp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rntp_pkg::item_t head_item
);
  import rntp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  item_t          entry_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: hdl/rntp_back.sv
module rntp_back #(
  parameter int VALUE_WIDTH = rntp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  rntp_pkg::item_t                 q_item,
  output logic                            q_pop,
  input  logic [rntp_pkg::RADIX_W-1:0]    radix,
  input  logic [rntp_pkg::MODE_W-1:0]     width_mode,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rntp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rntp_pkg::*;

  localparam int PW = VALUE_WIDTH + RADIX_W;
  localparam logic [6:0] VW7 = 7'(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   first_r, first_nxt;
  logic                   point_r, point_nxt;
  logic [FRAC_W-1:0]      frac_r, frac_nxt;
  status_t                err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   slot_free;
  logic [6:0]             eff_w;
  logic [VALUE_WIDTH-1:0] half;
  logic [VALUE_WIDTH-1:0] limit;
  logic [PW-1:0]          acc_sum;
  logic                   ovf;
  logic [OUT_VALUE_W-1:0] mag_ext;
  logic [OUT_VALUE_W-1:0] value;
  logic                   err_zero;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a terminator waits until the output register can take its result
  assign slot_free = !out_valid_r || out_tready;
  assign q_pop     = q_valid && (q_item.kind != KIND_NUL || slot_free);

  // saturation limit for the chosen width and sign
  always_comb begin
    if (width_mode == MODE_W16) eff_w = 7'd16;
    else if (width_mode == MODE_W32) eff_w = 7'd32;
    else eff_w = 7'd64;
    if (eff_w > VW7) eff_w = VW7;
    half  = VALUE_WIDTH'(1) << (eff_w - 7'd1);
    limit = neg_r ? half : half - 1'b1;
  end

  // multiply-add and overflow test
  always_comb begin
    acc_sum = PW'(mag_r) * PW'(eff_radix(radix)) + PW'(q_item.digit);
    ovf     = acc_sum > PW'(limit);
  end

  // signed result
  always_comb begin
    mag_ext  = OUT_VALUE_W'(mag_r);
    value    = neg_r ? (~mag_ext + 1'b1) : mag_ext;
    err_zero = (err_r == ST_BAD_DIGIT) || (err_r == ST_SECOND_POINT);
  end

  // parse state and output register
  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    point_nxt     = point_r;
    frac_nxt      = frac_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      if (q_item.kind == KIND_NUL) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {STATUS_W'(err_r),
                         err_zero ? '0 : frac_r,
                         err_zero ? '0 : value};
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        first_nxt = 1'b1;
        point_nxt = 1'b0;
        frac_nxt  = '0;
        err_nxt   = ST_OK;
      end else if (err_r != ST_OK) begin
        first_nxt = 1'b0;
      end else if (first_r && (q_item.kind == KIND_MINUS || q_item.kind == KIND_PLUS)) begin
        neg_nxt   = (q_item.kind == KIND_MINUS);
        first_nxt = 1'b0;
      end else begin
        first_nxt = 1'b0;
        unique case (q_item.kind)
          KIND_POINT: begin
            if (point_r) err_nxt = ST_SECOND_POINT;
            else point_nxt = 1'b1;
          end
          KIND_DIGIT: begin
            if (ovf) begin
              mag_nxt = limit;
              err_nxt = ST_OVERFLOW;
            end else begin
              mag_nxt = acc_sum[VALUE_WIDTH-1:0];
            end
            if (point_r) begin
              if (frac_r == FRAC_MAX) err_nxt = ST_OVERFLOW;
              else frac_nxt = frac_r + 1'b1;
            end
          end
          default: begin
            err_nxt = ST_BAD_DIGIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r       <= '0;
      neg_r       <= 1'b0;
      first_r     <= 1'b1;
      point_r     <= 1'b0;
      frac_r      <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      first_r     <= first_nxt;
      point_r     <= point_nxt;
      frac_r      <= frac_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// File: hdl/radix_number_text_parser.sv
// A terminating NUL is stored in the queue, then its result in the output register.
// Throughput: one character per cycle while the queue is not full; the digit multiply-add
// and overflow compare close the accumulator loop combinationally. A NUL waits for out_tready.
// Reset (rst_n low, synchronous): parse state, queue and output are cleared;
// radix returns to 10, width mode to 64 bits, decimal point disabled.
`include "radix_number_text_parser_macros.svh"

module radix_number_text_parser #(
  parameter int VALUE_WIDTH = rntp_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = rntp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rntp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] parsed_value, [69:64] fraction_digits, [71:70] parse_status
  output logic [rntp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [rntp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rntp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rntp_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [MODE_W-1:0]  mode_r;
  logic               allow_r;

  logic   q_full, q_push, q_pop, q_valid;
  item_t  push_item, head_item;

  logic [OUT_VALUE_W-1:0] out_value;
  logic [FRAC_W-1:0]      out_frac;
  logic [STATUS_W-1:0]    out_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
      mode_r  <= MODE_RST;
      allow_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIX:       radix_r <= cfg_data[RADIX_W-1:0];
        CFG_WIDTH_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        CFG_ALLOW_POINT: allow_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rntp_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .radix       (radix_r),
    .allow_point (allow_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  rntp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  rntp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .radix      (radix_r),
    .width_mode (mode_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // result fields for checking
  assign out_value  = out_tdata[OUT_VALUE_W-1:0];
  assign out_frac   = out_tdata[OUT_VALUE_W+FRAC_W-1:OUT_VALUE_W];
  assign out_status = out_tdata[OUT_TDATA_W-1:OUT_VALUE_W+FRAC_W];

  `RNTP_CHK_NOW(a_err_zero, !rst_n,
    out_tvalid && (out_status == ST_BAD_DIGIT || out_status == ST_SECOND_POINT),
    out_value == '0 && out_frac == '0,
    "bad digit or second point result carries nonzero fields")
  `RNTP_CHK_NOW(a_w16_range, !rst_n,
    out_tvalid && mode_r == MODE_W16,
    (&out_value[OUT_VALUE_W-1:15]) || !(|out_value[OUT_VALUE_W-1:15]),
    "16-bit mode result exceeds its signed range")
  `RNTP_CHK_NEXT(a_rst_idle, 1'b0,
    !rst_n,
    !out_tvalid && in_tready,
    "block not idle after reset")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rntp_pkg::*;

  localparam int DUT_VALUE_W  = VALUE_WIDTH_DEF;
  localparam int HOLD_CYCLES  = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_CHARS  = 140;
  localparam int PHASE_COUNT  = 12;
  localparam int SHOW_LIMIT   = 10;
  localparam int IDLE_PERCENT = 35;

  // one parsed number as it leaves the block
  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic [FRAC_W-1:0]      frac;
    status_t                status;
  } parse_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // characters waiting to be sent and numbers waiting to come back
  logic [CHAR_W-1:0] char_queue[$];
  parse_result_t     expected_numbers[$];

  // register copies
  logic [RADIX_W-1:0] radix_reg = RADIX_RST;
  logic [MODE_W-1:0]  mode_reg = MODE_RST;
  logic               point_reg = 1'b0;

  // parsing state of the predictor
  logic [OUT_VALUE_W-1:0] mag_acc = '0;
  logic                   sign_neg = 1'b0;
  logic                   fresh_start = 1'b1;
  logic                   dot_seen = 1'b0;
  logic [FRAC_W-1:0]      frac_cnt = '0;
  status_t                parse_err = ST_OK;

  bit steady_flow = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int numbers_sent = 0;
  int settings_used = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  radix_number_text_parser #(
    .VALUE_WIDTH(DUT_VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] char_code
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [63:0] parsed_value, [69:64] fraction_digits, [71:70] parse_status
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // radix clamped to 2..36
  function automatic int unsigned eff_base(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // saturation width, never above the block's value width
  function automatic int unsigned width_bits(input logic [MODE_W-1:0] m);
    int unsigned w;
    w = 64;
    if (m == MODE_W16) w = 16;
    else if (m == MODE_W32) w = 32;
    if (w > DUT_VALUE_W) w = DUT_VALUE_W;
    return w;
  endfunction

  // weight of a character, DIGIT_NONE when it is no digit
  function automatic int unsigned char_digit(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + LETTER_BASE;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + LETTER_BASE;
    return DIGIT_NONE;
  endfunction

  // character for a digit weight, letters in either case
  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d < LETTER_BASE) return CHAR_W'(CH_ZERO + d);
    if ($urandom_range(0, 1) == 0) return CHAR_W'(CH_LO_A + d - LETTER_BASE);
    return CHAR_W'(CH_UP_A + d - LETTER_BASE);
  endfunction

  task automatic clear_parser();
    mag_acc = '0;
    sign_neg = 1'b0;
    fresh_start = 1'b1;
    dot_seen = 1'b0;
    frac_cnt = '0;
    parse_err = ST_OK;
  endtask

  // advance the predicted parser by one accepted character
  task automatic advance_parser(input logic [CHAR_W-1:0] ch);
    logic [OUT_VALUE_W-1:0] half, lim, dval, base;
    parse_result_t res;
    if (ch == CH_NUL) begin
      res.value = sign_neg ? -mag_acc : mag_acc;
      res.frac = frac_cnt;
      res.status = parse_err;
      if (parse_err == ST_BAD_DIGIT || parse_err == ST_SECOND_POINT) begin
        res.value = '0;
        res.frac = '0;
      end
      expected_numbers.push_back(res);
      clear_parser();
    end else if (parse_err != ST_OK) begin
      // first error sticks until the terminator
      fresh_start = 1'b0;
    end else if (fresh_start && (ch == CH_MINUS || ch == CH_PLUS)) begin
      sign_neg = (ch == CH_MINUS);
      fresh_start = 1'b0;
    end else begin
      fresh_start = 1'b0;
      if (ch == CH_POINT) begin
        if (!point_reg) parse_err = ST_BAD_DIGIT;
        else if (dot_seen) parse_err = ST_SECOND_POINT;
        else dot_seen = 1'b1;
      end else begin
        base = eff_base(radix_reg);
        dval = char_digit(ch);
        if (dval >= base) begin
          parse_err = ST_BAD_DIGIT;
        end else begin
          half = 64'd1 << (width_bits(mode_reg) - 1);
          lim = sign_neg ? half : half - 1;
          if (mag_acc > (lim - dval) / base) begin
            mag_acc = lim;
            parse_err = ST_OVERFLOW;
          end else begin
            mag_acc = mag_acc * base + dval;
          end
          if (dot_seen) begin
            if (frac_cnt == FRAC_MAX) parse_err = ST_OVERFLOW;
            else frac_cnt = frac_cnt + 1'b1;
          end
        end
      end
    end
  endtask

  // sender: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_parser(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (char_queue.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_tdata <= char_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  // result checker
  always @(posedge clk) begin
    parse_result_t want;
    logic [OUT_VALUE_W-1:0] got_value;
    logic [FRAC_W-1:0] got_frac;
    logic [STATUS_W-1:0] got_status;
    if (rst_n && out_tvalid && out_tready) begin
      got_value = out_tdata[63:0];
      got_frac = out_tdata[69:64];
      got_status = out_tdata[71:70];
      if (expected_numbers.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected result: value %h frac %0d status %0d",
                   got_value, got_frac, got_status);
      end else begin
        want = expected_numbers.pop_front();
        status_seen[want.status]++;
        if (got_value !== want.value || got_frac !== want.frac ||
            got_status !== want.status) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("mismatch: value exp %h got %h, frac exp %0d got %0d, status exp %0d got %0d",
                     want.value, got_value, want.frac, got_frac, want.status, got_status);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_char(input logic [CHAR_W-1:0] ch);
    char_queue.push_back(ch);
    chars_sent++;
    if (ch == CH_NUL) numbers_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(CH_NUL);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_RADIX) radix_reg = val;
    else if (idx == CFG_WIDTH_MODE) mode_reg = val[MODE_W-1:0];
    else if (idx == CFG_ALLOW_POINT) point_reg = val[0];
  endtask

  // block drained: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (char_queue.size() != 0 || in_tvalid || expected_numbers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one number text: mostly well formed, some broken, some very long
  task automatic queue_number();
    int unsigned base, len, dot_at, roll;
    base = eff_base(radix_reg);
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: push_char(CH_MINUS);
      1: push_char(CH_PLUS);
      default: ;
    endcase
    // long run of zeros after a point to exhaust the fraction counter
    if (roll < 3) begin
      push_char(CH_POINT);
      repeat ($urandom_range(62, 66)) push_char(CH_ZERO);
      push_char(CH_NUL);
      return;
    end
    if (roll < 68) len = $urandom_range(0, 6);
    else if (roll < 85) len = $urandom_range(5, 70);
    else len = $urandom_range(1, 8);
    dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : len + 1;
    for (int i = 0; i < len; i++) begin
      if (i == dot_at) push_char(CH_POINT);
      // bias toward the top digit so saturation is reached
      if ($urandom_range(0, 3) == 0) push_char(digit_char(base - 1));
      else push_char(digit_char($urandom_range(0, base - 1)));
    end
    if (dot_at == len) push_char(CH_POINT);
    // broken tail
    if (roll >= 85) begin
      case ($urandom_range(0, 4))
        0: push_char(CHAR_W'($urandom_range(1, 255)));
        1: begin
          push_char(CH_POINT);
          push_char(CH_POINT);
        end
        2: push_char(($urandom_range(0, 1) == 0) ? CH_MINUS : CH_PLUS);
        3: push_char((base < RADIX_MAX)
                     ? digit_char($urandom_range(base, RADIX_MAX - 1))
                     : CHAR_W'($urandom_range(1, 255)));
        default: push_char(CHAR_W'($urandom_range(128, 255)));
      endcase
      if ($urandom_range(0, 1) == 0) push_char(digit_char($urandom_range(0, base - 1)));
    end
    push_char(CH_NUL);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: radix 10, 64 bit, no point
    settings_used++;
    push_text("");
    push_text("+9");
    push_text("-0.");
    push_text("1-");
    push_text("a");
    push_char(8'hFF);
    push_char(CH_NUL);
    wait_idle();

    // 16 bit hex with point: exact limits, overflow, second point, point alone
    write_reg(CFG_RADIX, 6'd16);
    write_reg(CFG_WIDTH_MODE, CFG_DATA_W'(MODE_W16));
    write_reg(CFG_ALLOW_POINT, 6'd1);
    settings_used++;
    push_text("-8000");
    push_text("7FFF");
    push_text("8000");
    push_text("1.f.");
    push_text("-.");
    wait_idle();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RADIX, 6'd2);
          write_reg(CFG_WIDTH_MODE, 6'd0);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        1: begin
          write_reg(CFG_RADIX, 6'd36);
          write_reg(CFG_WIDTH_MODE, 6'd2);
          write_reg(CFG_ALLOW_POINT, 6'd0);
        end
        2: begin
          write_reg(CFG_RADIX, 6'd0);
          write_reg(CFG_WIDTH_MODE, 6'd1);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        3: begin
          write_reg(CFG_RADIX, 6'd63);
          write_reg(CFG_WIDTH_MODE, 6'd3);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        4: begin
          write_reg(CFG_RADIX, 6'd10);
          write_reg(CFG_WIDTH_MODE, 6'd0);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        5: begin
          write_reg(CFG_RADIX, 6'd16);
          write_reg(CFG_WIDTH_MODE, 6'd1);
          write_reg(CFG_ALLOW_POINT, 6'd0);
        end
        6: begin
          write_reg(CFG_RADIX, 6'd8);
          write_reg(CFG_WIDTH_MODE, 6'd0);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        7: begin
          write_reg(CFG_RADIX, 6'd37);
          write_reg(CFG_WIDTH_MODE, 6'd2);
          write_reg(CFG_ALLOW_POINT, 6'd1);
        end
        8: begin
          write_reg(CFG_RADIX, 6'd1);
          write_reg(CFG_WIDTH_MODE, 6'd3);
          write_reg(CFG_ALLOW_POINT, 6'd0);
        end
        default: begin
          write_reg(CFG_RADIX, CFG_DATA_W'($urandom_range(0, 63)));
          write_reg(CFG_WIDTH_MODE, CFG_DATA_W'($urandom_range(0, 3)));
          write_reg(CFG_ALLOW_POINT, CFG_DATA_W'($urandom_range(0, 1)));
        end
      endcase
      settings_used++;

      // two phases run without idling; the second one also holds off the receiver
      steady_flow = (ph == 3 || ph == 4);
      if (ph == 4) hold_req = 1'b1;

      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        queue_number();
        // sender pause until every number has come back
        if (ph == 7 && chars_sent - phase_start >= PHASE_CHARS / 2 &&
            chars_sent - phase_start < PHASE_CHARS / 2 + 12)
          wait_idle();
      end
      wait_idle();
    end
    steady_flow = 1'b0;

    $display("sent %0d characters forming %0d numbers under %0d register settings",
             chars_sent, numbers_sent, settings_used);
    $display("numbers by status: ok %0d, bad digit %0d, second point %0d, saturated %0d",
             status_seen[ST_OK], status_seen[ST_BAD_DIGIT],
             status_seen[ST_SECOND_POINT], status_seen[ST_OVERFLOW]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
